### rtl/core/circular_fifo_queue_defines.svh
// assertion macros shared by the fifo rtl
// no dependencies
`ifndef CIRCULAR_FIFO_QUEUE_DEFINES_SVH
`define CIRCULAR_FIFO_QUEUE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define CFQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define CFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/cfq_pkg.sv
// types and codes for the circular fifo queue
// no dependencies
package cfq_pkg;

    localparam logic       REQ_ENQ  = 1'b0;
    localparam logic       REQ_DEQ  = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] popped_value;
        logic [3:0]         occupancy;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic               is_empty;
    } t_out_item;

    typedef struct packed {
        logic               push;
        logic               pop;
        logic signed [31:0] value;
    } t_cell_cmd;

endpackage

### rtl/core/cfq_cell.sv
// one storage cell of the queue chain
// depends on cfq_pkg
module cfq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cfq_pkg::t_cell_cmd  i_cmd,
    input  logic                i_prev_valid,
    input  logic                i_nb_valid,
    input  logic signed [31:0]  i_nb_data,
    output logic                o_valid,
    output logic signed [31:0]  o_data
);
    import cfq_pkg::*;

    logic               r_valid;
    logic signed [31:0] r_data;
    logic               n_valid;
    logic signed [31:0] n_data;

    always_comb begin
        priority if (i_cmd.pop) begin
            n_valid = i_nb_valid;
            n_data  = i_nb_data;
        end else if (i_cmd.push && !r_valid && i_prev_valid) begin
            n_valid = 1'b1;
            n_data  = i_cmd.value;
        end else begin
            n_valid = r_valid;
            n_data  = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/core/circular_fifo_queue.sv
// a result is registered and appears in the cycle after its request is accepted
// throughput: one request per cycle while the result side takes items
// storage is a chain of cells shifting towards the head on each dequeue
// reset clears the cell valid bits, the count and the output valid flag
// depends on cfq_pkg, cfq_cell and circular_fifo_queue_defines.svh
`include "circular_fifo_queue_defines.svh"

module circular_fifo_queue #(
    parameter int DEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cfq_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cfq_pkg::t_out_item o_out_item
);
    import cfq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [DEPTH-1:0]   w_valid;
    logic signed [31:0] w_data [DEPTH];
    t_cell_cmd          w_cmd;

    logic               r_out_valid;
    t_out_item          r_out_item;
    t_out_item          n_out_item;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic signed [31:0] r_back;
    logic signed [31:0] n_back;
    logic signed [31:0] w_front;

    logic w_accept;
    logic w_full;
    logic w_empty;
    logic w_enq;
    logic w_deq;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = w_valid[DEPTH-1];
    assign w_empty    = !w_valid[0];
    assign w_enq      = w_accept && (i_in_item.req_type == REQ_ENQ) && !w_full;
    assign w_deq      = w_accept && (i_in_item.req_type == REQ_DEQ) && !w_empty;

    assign w_cmd.push  = w_enq;
    assign w_cmd.pop   = w_deq;
    assign w_cmd.value = i_in_item.item_value;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic               w_prev_valid;
        logic               w_nb_valid;
        logic signed [31:0] w_nb_data;

        if (g == 0) begin : g_head
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_valid = w_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_nb_valid = 1'b0;
            assign w_nb_data  = '0;
        end else begin : g_link
            assign w_nb_valid = w_valid[g+1];
            assign w_nb_data  = w_data[g+1];
        end

        cfq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_prev_valid (w_prev_valid),
            .i_nb_valid   (w_nb_valid),
            .i_nb_data    (w_nb_data),
            .o_valid      (w_valid[g]),
            .o_data       (w_data[g])
        );
    end

    always_comb begin
        priority if (w_enq) begin
            n_count = r_count + CW'(1);
            n_back  = i_in_item.item_value;
        end else if (w_deq) begin
            n_count = r_count - CW'(1);
            n_back  = r_back;
        end else begin
            n_count = r_count;
            n_back  = r_back;
        end

        priority if (w_deq) begin
            w_front = w_valid[1] ? w_data[1] : 32'sd0;
        end else if (w_valid[0]) begin
            w_front = w_data[0];
        end else if (w_enq) begin
            w_front = i_in_item.item_value;
        end else begin
            w_front = '0;
        end

        n_out_item.status       = ST_DONE;
        if (i_in_item.req_type == REQ_ENQ && w_full) begin
            n_out_item.status   = ST_FULL;
        end else if (i_in_item.req_type == REQ_DEQ && w_empty) begin
            n_out_item.status   = ST_EMPTY;
        end
        n_out_item.popped_value = w_deq ? w_data[0] : 32'sd0;
        n_out_item.occupancy    = 4'(n_count);
        n_out_item.is_empty     = (n_count == '0);
        n_out_item.front_value  = (n_count == '0) ? 32'sd0 : w_front;
        n_out_item.back_value   = (n_count == '0) ? 32'sd0 : n_back;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_count <= n_count;
        end
        r_back <= n_back;
        if (w_accept) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `CFQ_ASSERT_NOW(a_count_matches_cells, i_clk, i_rst_n, 1'b1,
        $countones(w_valid) == 32'(r_count), "count differs from valid cells")
    `CFQ_ASSERT_NOW(a_cells_contiguous, i_clk, i_rst_n, w_valid[DEPTH-1],
        &w_valid, "valid cells not packed at the head")
    `CFQ_ASSERT_NEXT(a_full_rejects, i_clk, i_rst_n,
        w_accept && i_in_item.req_type == REQ_ENQ && w_full,
        o_out_item.status == ST_FULL && w_valid[DEPTH-1], "enqueue to full queue not rejected")
    `CFQ_ASSERT_NOW(a_empty_fields, i_clk, i_rst_n, o_out_valid && o_out_item.is_empty,
        o_out_item.front_value == 32'sd0 && o_out_item.back_value == 32'sd0,
        "empty result carries values")

endmodule

### tb/sv/tb.sv
// self-checking testbench for circular_fifo_queue: a scoreboard class mirrors the fifo state
// and checks every result, while plain tasks drive requests and an always block drives random backpressure
// depends on cfq_pkg and the circular_fifo_queue rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cfq_pkg::*;

    localparam int FIFO_DEPTH  = 8;
    localparam int IDLE_PCT    = 21;
    localparam int STALL_LIMIT = 2000;
    localparam int RAND_ITEMS  = 1450;

    class fifo_scoreboard;
        logic signed [31:0] slot_mem [FIFO_DEPTH];
        int unsigned        head_idx;
        int unsigned        tail_idx;
        int unsigned        fill;
        t_out_item          expected_q [$];
        int unsigned        requests;
        int unsigned        checked;
        int unsigned        mismatches;
        int unsigned        full_rejects;
        int unsigned        empty_rejects;

        function new();
            head_idx      = 0;
            tail_idx      = 0;
            fill          = 0;
            requests      = 0;
            checked       = 0;
            mismatches    = 0;
            full_rejects  = 0;
            empty_rejects = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_request(t_in_item it);
            t_out_item res;
            res        = '0;
            res.status = ST_DONE;
            requests++;
            if (it.req_type == REQ_ENQ) begin
                if (fill >= FIFO_DEPTH) begin
                    res.status = ST_FULL;
                    full_rejects++;
                end else begin
                    slot_mem[tail_idx] = it.item_value;
                    tail_idx = (tail_idx + 1) % FIFO_DEPTH;
                    fill++;
                end
            end else begin
                if (fill == 0) begin
                    res.status = ST_EMPTY;
                    empty_rejects++;
                end else begin
                    res.popped_value = slot_mem[head_idx];
                    head_idx = (head_idx + 1) % FIFO_DEPTH;
                    fill--;
                end
            end
            res.occupancy = 4'(fill);
            res.is_empty  = (fill == 0);
            if (fill != 0) begin
                res.front_value = slot_mem[head_idx];
                res.back_value  = slot_mem[(tail_idx + FIFO_DEPTH - 1) % FIFO_DEPTH];
            end
            expected_q.push_back(res);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch at result %0d: %s got %0h want %0h", checked, what, got, want);
            mismatches++;
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected item", 32'(got.status), 32'(0));
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.popped_value !== want.popped_value)
                report_mismatch("popped_value", got.popped_value, want.popped_value);
            if (got.occupancy !== want.occupancy)
                report_mismatch("occupancy", 32'(got.occupancy), 32'(want.occupancy));
            if (got.front_value !== want.front_value)
                report_mismatch("front_value", got.front_value, want.front_value);
            if (got.back_value !== want.back_value)
                report_mismatch("back_value", got.back_value, want.back_value);
            if (got.is_empty !== want.is_empty)
                report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
            checked++;
        endtask
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;
    logic      quiet     = 1'b0;
    int        stall_cycles = 0;

    fifo_scoreboard sb = new();

    circular_fifo_queue #(
        .DEPTH(FIFO_DEPTH)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.note_request(in_item);
            if (out_valid && out_ready)
                sb.check_result(out_item);
        end
    end

    always @(negedge clk) begin
        out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout after %0d cycles without an item", STALL_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // called just after a falling edge, returns just after a falling edge
    task automatic send_item(logic req, logic signed [31:0] value);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{req_type: req, item_value: value};
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain_pause();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int sent;
        int burst;
        int enq_pct;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty reject, fill with extremes, full reject, wrap, drain, empty reject
        send_item(REQ_DEQ, 32'sh1234_5678);
        send_item(REQ_ENQ, 32'sh8000_0000);
        send_item(REQ_ENQ, 32'sh7fff_ffff);
        send_item(REQ_ENQ, 32'sh0000_0000);
        send_item(REQ_ENQ, -32'sd1);
        send_item(REQ_ENQ, 32'sh5555_5555);
        send_item(REQ_ENQ, 32'shaaaa_aaaa);
        send_item(REQ_ENQ, 32'sh0000_0001);
        send_item(REQ_ENQ, 32'sh8000_0001);
        send_item(REQ_ENQ, 32'sh0bad_f00d);
        send_item(REQ_DEQ, 32'sh0);
        send_item(REQ_DEQ, 32'sh0);
        send_item(REQ_DEQ, 32'sh0);
        send_item(REQ_ENQ, 32'sh1111_1111);
        send_item(REQ_ENQ, 32'sh2222_2222);
        send_item(REQ_ENQ, 32'sh3333_3333);
        send_item(REQ_ENQ, 32'sh4444_4444);
        repeat (8) send_item(REQ_DEQ, 32'shffff_ffff);
        send_item(REQ_DEQ, 32'sh0);

        // random bursts biased towards filling, draining or neither
        sent = 0;
        while (sent < RAND_ITEMS) begin
            burst = $urandom_range(10, 60);
            case ($urandom_range(3))
                0:       enq_pct = 85;
                1:       enq_pct = 15;
                2:       enq_pct = 50;
                default: enq_pct = $urandom_range(100);
            endcase
            repeat (burst) begin
                quiet <= (sent >= 300 && sent < 500);
                if (sent == 750)
                    drain_pause();
                send_item(($urandom_range(99) < enq_pct) ? REQ_ENQ : REQ_DEQ, pick_value());
                sent++;
            end
        end
        in_valid <= 1'b0;
        quiet    <= 1'b0;

        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);

        $display("%0d requests sent, %0d results checked", sb.requests, sb.checked);
        $display("%0d rejected as full, %0d rejected as empty",
                 sb.full_rejects, sb.empty_rejects);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
